>>> design/atoi_bp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atoi_bp_pkg;

   // Datapath sizing
   localparam int MAX_BASE       = 16;
   localparam int ACC_WIDTH      = 32;
   localparam int VALUE_WIDTH    = 32;
   localparam int CHAR_WIDTH     = 8;
   localparam int LEN_WIDTH      = 5;
   localparam int DIGIT_WIDTH    = $clog2(MAX_BASE);
   localparam int ALPHA_WIDTH    = 64;
   localparam int CHARS_PER_WORD = ALPHA_WIDTH / CHAR_WIDTH;

   // CSR port
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 64;

   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;
   typedef logic [CHAR_WIDTH-1:0]     char_type;
   typedef logic [LEN_WIDTH-1:0]      len_type;
   typedef logic [ACC_WIDTH-1:0]      acc_type;

   localparam csr_addr_type REG_ALPHABET_LOW  = 2'd0;
   localparam csr_addr_type REG_ALPHABET_HIGH = 2'd1;
   localparam csr_addr_type REG_BASE_LENGTH   = 2'd2;

   // Reset alphabet is "0123456789"
   localparam logic [ALPHA_WIDTH-1:0] ALPHABET_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [ALPHA_WIDTH-1:0] ALPHABET_HIGH_RESET = 64'h0000_0000_0000_3938;
   localparam len_type                BASE_LENGTH_RESET   = 5'd10;

   // Scan phases
   typedef logic [1:0] phase_type;
   localparam phase_type PH_SPACE = 2'd0;
   localparam phase_type PH_SIGN  = 2'd1;
   localparam phase_type PH_DIGIT = 2'd2;
   localparam phase_type PH_DONE  = 2'd3;

   // Character codes
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;

endpackage

`default_nettype wire

>>> design/atoi_base_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// The result transaction is registered and valid in the cycle after the transaction carrying tlast.
// Throughput: one character per cycle; req_tready = !rsp_tvalid || rsp_tready, so
//   only an unaccepted result held in the output register stalls the input.
// Per-character work is one alphabet compare, one multiply-add and a negate.
// Reset (synchronous, active high) restores the decimal alphabet, clears the
//   scan state and drops rsp_tvalid.
module atoi_base_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   // CSR write port
   input  logic                                   csr_we,
   input  logic [atoi_bp_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [atoi_bp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   // Character stream in
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [7:0] ch
   input  logic                                   req_tlast,   // last character of string
   // Parsed value out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [31:0]                            rsp_tdata,   // [31:0] value
   output logic                                   rsp_tuser    // [0] base_error
);

   import atoi_bp_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [ALPHA_WIDTH-1:0] alphabet_low_ff;
   logic [ALPHA_WIDTH-1:0] alphabet_high_ff;
   len_type                base_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_low_ff  <= ALPHABET_LOW_RESET;
         alphabet_high_ff <= ALPHABET_HIGH_RESET;
         base_length_ff   <= BASE_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ALPHABET_LOW:  alphabet_low_ff  <= csr_wdata[ALPHA_WIDTH-1:0];
            REG_ALPHABET_HIGH: alphabet_high_ff <= csr_wdata[ALPHA_WIDTH-1:0];
            REG_BASE_LENGTH:   base_length_ff   <= csr_wdata[LEN_WIDTH-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // Alphabet unpacked into one byte per digit slot
   char_type alpha [MAX_BASE];
   logic     slot_used [MAX_BASE];

   always_comb begin
      for (int i = 0; i < MAX_BASE; i++) begin
         if (i < CHARS_PER_WORD) begin
            alpha[i] = alphabet_low_ff[(i % CHARS_PER_WORD)*CHAR_WIDTH +: CHAR_WIDTH];
         end else begin
            alpha[i] = alphabet_high_ff[(i % CHARS_PER_WORD)*CHAR_WIDTH +: CHAR_WIDTH];
         end
         // lengths above MAX_BASE still enable every slot
         slot_used[i] = LEN_WIDTH'(i) < base_length_ff;
      end
   end

   function automatic logic is_space(input char_type c);
      return (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
   endfunction

   // ---------------------------------------------------------------
   // Alphabet check: length range, forbidden characters, duplicates
   // ---------------------------------------------------------------
   logic base_bad;

   always_comb begin
      base_bad = (base_length_ff < LEN_WIDTH'(2)) || (base_length_ff > LEN_WIDTH'(MAX_BASE));
      for (int i = 0; i < MAX_BASE; i++) begin
         if (slot_used[i]) begin
            if (alpha[i] == CH_PLUS || alpha[i] == CH_MINUS || alpha[i] == CH_NUL ||
                is_space(alpha[i])) begin
               base_bad = 1'b1;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (slot_used[j] && alpha[j] == alpha[i]) begin
                  base_bad = 1'b1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Scan state and next-state logic
   // ---------------------------------------------------------------
   phase_type phase_ff, phase_in;
   logic      negative_ff, negative_in;
   acc_type   acc_ff, acc_in;

   char_type                 ch;
   logic                     ch_space;
   logic                     ch_sign;
   logic                     digit_hit;
   logic [DIGIT_WIDTH-1:0]   digit_val;
   acc_type                  signed_acc;
   logic [VALUE_WIDTH-1:0]   value_in;

   assign ch = req_tdata[CHAR_WIDTH-1:0];

   // Lowest matching slot wins; loop runs downward so the last assignment is the lowest.
   always_comb begin
      digit_hit = 1'b0;
      digit_val = '0;
      for (int i = MAX_BASE - 1; i >= 0; i--) begin
         if (slot_used[i] && ch != CH_NUL && alpha[i] == ch) begin
            digit_hit = 1'b1;
            digit_val = DIGIT_WIDTH'(i);
         end
      end
   end

   always_comb begin
      ch_space    = is_space(ch);
      ch_sign     = (ch == CH_PLUS) || (ch == CH_MINUS);
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;

      if (phase_ff == PH_SPACE && ch_space) begin
         // still skipping leading whitespace
      end else if ((phase_ff == PH_SPACE || phase_ff == PH_SIGN) && ch_sign) begin
         if (ch == CH_MINUS) begin
            negative_in = !negative_ff;
         end
         phase_in = PH_SIGN;
      end else if (phase_ff != PH_DONE && digit_hit) begin
         // multiply by the raw register value, wraps at ACC_WIDTH
         acc_in   = ACC_WIDTH'(acc_ff * ACC_WIDTH'(base_length_ff)) + ACC_WIDTH'(digit_val);
         phase_in = PH_DIGIT;
      end else begin
         phase_in = PH_DONE;
      end

      signed_acc = negative_in ? (ACC_WIDTH'(0) - acc_in) : acc_in;
      // sign-extend or truncate the accumulator to the output width
      value_in   = base_bad ? '0 : VALUE_WIDTH'(signed'(signed_acc));
   end

   // ---------------------------------------------------------------
   // Handshake and registers
   // ---------------------------------------------------------------
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   base_error_ff;
   logic                   req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            if (req_tlast) begin
               // string done: back to the start state
               phase_ff    <= PH_SPACE;
               negative_ff <= 1'b0;
               acc_ff      <= '0;
            end else begin
               phase_ff    <= phase_in;
               negative_ff <= negative_in;
               acc_ff      <= acc_in;
            end
         end

         if (req_accept && req_tlast) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_tlast) begin
         value_ff      <= value_in;
         base_error_ff <= base_bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = base_error_ff;

`ifndef SYNTHESIS
   // An invalid alphabet always reports zero.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("base error with nonzero value");

   // The end of a string returns the scan to its start state.
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=>
         phase_ff == PH_SPACE && !negative_ff && acc_ff == '0 && rsp_valid_ff)
      else $error("scan state not cleared after last character");

   // Once the scan has ended, later characters before the last do not restart it.
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_tlast && phase_ff == PH_DONE |=>
         phase_ff == PH_DONE && $stable(acc_ff) && $stable(negative_ff))
      else $error("scan resumed after end");

   // Characters that are not the last never produce a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(req_accept && req_tlast) |=> !rsp_valid_ff)
      else $error("result without a last character");
`endif

endmodule

`default_nettype wire
